@@ sv/iirs_pkg.sv @@
// Package for the summed-area table block: sizes, codes and the command word
// passed from the front end to the back end. No dependencies.
`timescale 1ns / 1ps

package iirs_pkg;

  localparam int MAX_ROWS     = 64;
  localparam int MAX_COLUMNS  = 64;
  localparam int ROW_W        = $clog2(MAX_ROWS);
  localparam int COL_W        = $clog2(MAX_COLUMNS);
  localparam int ADDR_W       = ROW_W + COL_W;
  localparam int STORE_DEPTH  = MAX_ROWS * MAX_COLUMNS;
  localparam int COORD_W      = 6;
  localparam int VALUE_W      = 32;
  localparam int SUM_W        = 64;
  localparam int STATUS_W     = 2;
  localparam int SIZE_W       = 7;
  localparam int CFG_INDEX_W  = 2;
  localparam int QUEUE_DEPTH  = 4;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
  localparam int CORNERS      = 4;

  typedef logic [STATUS_W-1:0]    status_t;
  typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

  localparam cfg_index_t REG_ROWS_IN_USE    = 2'd0;
  localparam cfg_index_t REG_COLUMNS_IN_USE = 2'd1;

  localparam status_t STATUS_OK         = 2'd0;
  localparam status_t STATUS_INVERTED   = 2'd1;
  localparam status_t STATUS_OUTSIDE    = 2'd2;
  localparam status_t STATUS_NOT_LOADED = 2'd3;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef struct packed {
    logic                            is_query;
    status_t                         status;
    logic [CORNERS-1:0][ADDR_W-1:0]  corner_addr;
    logic [CORNERS-1:0]              corner_used;
    logic [ADDR_W-1:0]               write_addr;
    logic [SUM_W-1:0]                load_sum;
  } cmd_t;

endpackage

@@ sv/iirs_if.sv @@
// Handshake interfaces for the item, result and configuration channels.
// Depends on iirs_pkg.
`timescale 1ns / 1ps

interface iirs_item_if import iirs_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic                       kind;
  logic signed [VALUE_W-1:0]  cell_value;
  logic [COORD_W-1:0]         top_row;
  logic [COORD_W-1:0]         left_column;
  logic [COORD_W-1:0]         bottom_row;
  logic [COORD_W-1:0]         right_column;

  modport source (output valid, kind, cell_value, top_row, left_column, bottom_row,
                  right_column, input ready);
  modport sink (input valid, kind, cell_value, top_row, left_column, bottom_row,
                right_column, output ready);
endinterface

interface iirs_result_if import iirs_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [SUM_W-1:0]  region_sum;
  status_t                  status;

  modport source (output valid, region_sum, status, input ready);
  modport sink (input valid, region_sum, status, output ready);
endinterface

interface iirs_cfg_if import iirs_pkg::*; ();
  logic               valid;
  logic               ready;
  cfg_index_t         reg_index;
  logic [SIZE_W-1:0]  reg_data;

  modport source (output valid, reg_index, reg_data, input ready);
  modport sink (input valid, reg_index, reg_data, output ready);
endinterface

@@ sv/iirs_front.sv @@
// Front end: holds the size registers and the load position, accepts items
// and turns each into a command word. Depends on iirs_pkg and iirs_if.
`timescale 1ns / 1ps

module iirs_front import iirs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  iirs_item_if.sink   item,
  iirs_cfg_if.sink    cfg,
  input  logic        queue_full,
  output logic        push,
  output cmd_t        push_cmd
);

  logic [SIZE_W-1:0]  rows_in_use;
  logic [SIZE_W-1:0]  columns_in_use;
  logic [ROW_W-1:0]   load_row;
  logic [COL_W-1:0]   load_column;
  logic [SUM_W-1:0]   row_running_sum;
  logic               frame_complete;

  logic               restart;
  logic [ROW_W-1:0]   cur_row;
  logic [COL_W-1:0]   cur_col;
  logic [SUM_W-1:0]   new_sum;
  logic [SIZE_W-1:0]  row_inc;
  logic [SIZE_W-1:0]  col_inc;
  logic               row_end;
  logic               frame_end;
  logic               item_take;
  logic               cfg_take;
  status_t            query_status;

  function automatic logic [SIZE_W-1:0] clamp_size(logic [SIZE_W-1:0] v, int limit);
    logic [SIZE_W-1:0] r;
    r = v;
    if (r == '0) begin
      r = SIZE_W'(1);
    end
    if (r > SIZE_W'(limit)) begin
      r = SIZE_W'(limit);
    end
    return r;
  endfunction

  assign item.ready = !queue_full;
  assign cfg.ready  = 1'b1;
  assign item_take  = item.valid && item.ready;
  assign cfg_take   = cfg.valid && cfg.ready;
  assign push       = item_take;

  always_comb begin
    restart = frame_complete || ({1'b0, load_row} >= rows_in_use) ||
              ({1'b0, load_column} >= columns_in_use);
    cur_row   = restart ? '0 : load_row;
    cur_col   = restart ? '0 : load_column;
    new_sum   = (restart ? '0 : row_running_sum) +
                {{(SUM_W-VALUE_W){item.cell_value[VALUE_W-1]}}, item.cell_value};
    row_inc   = {1'b0, cur_row} + SIZE_W'(1);
    col_inc   = {1'b0, cur_col} + SIZE_W'(1);
    row_end   = col_inc >= columns_in_use;
    frame_end = row_end && (row_inc >= rows_in_use);

    if (item.bottom_row < item.top_row || item.right_column < item.left_column) begin
      query_status = STATUS_INVERTED;
    end else if ({1'b0, item.bottom_row} >= rows_in_use ||
                 {1'b0, item.right_column} >= columns_in_use) begin
      query_status = STATUS_OUTSIDE;
    end else if (!frame_complete) begin
      query_status = STATUS_NOT_LOADED;
    end else begin
      query_status = STATUS_OK;
    end

    push_cmd = '0;
    if (item.kind == KIND_QUERY) begin
      push_cmd.is_query       = 1'b1;
      push_cmd.status         = query_status;
      push_cmd.corner_addr[0] = {item.bottom_row, item.right_column};
      push_cmd.corner_addr[1] = {item.top_row - 6'd1, item.right_column};
      push_cmd.corner_addr[2] = {item.bottom_row, item.left_column - 6'd1};
      push_cmd.corner_addr[3] = {item.top_row - 6'd1, item.left_column - 6'd1};
      push_cmd.corner_used    = {item.top_row != '0 && item.left_column != '0,
                                 item.left_column != '0, item.top_row != '0, 1'b1};
    end else begin
      push_cmd.is_query       = 1'b0;
      push_cmd.status         = STATUS_OK;
      push_cmd.corner_addr[0] = {cur_row - ROW_W'(1), cur_col};
      push_cmd.corner_used[0] = cur_row != '0;
      push_cmd.write_addr     = {cur_row, cur_col};
      push_cmd.load_sum       = new_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_in_use     <= SIZE_W'(MAX_ROWS);
      columns_in_use  <= SIZE_W'(MAX_COLUMNS);
      load_row        <= '0;
      load_column     <= '0;
      row_running_sum <= '0;
      frame_complete  <= 1'b0;
    end else if (cfg_take) begin
      if (cfg.reg_index == REG_ROWS_IN_USE) begin
        rows_in_use <= clamp_size(cfg.reg_data, MAX_ROWS);
      end
      if (cfg.reg_index == REG_COLUMNS_IN_USE) begin
        columns_in_use <= clamp_size(cfg.reg_data, MAX_COLUMNS);
      end
      if (cfg.reg_index == REG_ROWS_IN_USE || cfg.reg_index == REG_COLUMNS_IN_USE) begin
        load_row        <= '0;
        load_column     <= '0;
        row_running_sum <= '0;
        frame_complete  <= 1'b0;
      end
    end else if (item_take && item.kind == KIND_LOAD) begin
      if (row_end) begin
        load_column     <= '0;
        row_running_sum <= '0;
        if (frame_end) begin
          load_row       <= '0;
          frame_complete <= 1'b1;
        end else begin
          load_row       <= row_inc[ROW_W-1:0];
          frame_complete <= 1'b0;
        end
      end else begin
        load_row        <= cur_row;
        load_column     <= col_inc[COL_W-1:0];
        row_running_sum <= new_sum;
        frame_complete  <= 1'b0;
      end
    end
  end

endmodule

@@ sv/iirs_queue.sv @@
// Short command queue between the front end and the back end.
// Depends on iirs_pkg.
`timescale 1ns / 1ps

module iirs_queue import iirs_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  cmd_t  push_cmd,
  input  logic  pop,
  output cmd_t  head,
  output logic  empty,
  output logic  full
);

  cmd_t               slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QPTR_W:0]    count;

  assign empty = count == '0;
  assign full  = count == (QPTR_W+1)'(QUEUE_DEPTH);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      count <= count + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("command queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("command queue read while empty");

endmodule

@@ sv/iirs_back.sv @@
// Back end: owns the table memory, writes load entries and combines the four
// corner reads of a query into one result word. Depends on iirs_pkg and iirs_if.
`timescale 1ns / 1ps

module iirs_back import iirs_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  input  cmd_t           head,
  input  logic           empty,
  output logic           pop,
  iirs_result_if.source  result
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_READ   = 5'b00010,
    S_FINISH = 5'b00100,
    S_WRITE  = 5'b01000,
    S_OUT    = 5'b10000
  } state_t;

  state_t              state;
  state_t              state_next;
  cmd_t                cur;
  logic [1:0]          step;
  logic [SUM_W-1:0]    acc;
  logic                pend_valid;
  logic                pend_used;
  logic                pend_neg;
  logic [SUM_W-1:0]    store [STORE_DEPTH];
  logic [SUM_W-1:0]    rdata;
  logic [ADDR_W-1:0]   raddr;
  logic                we;
  logic                last_step;
  logic                out_free;

  assign pop       = state == S_IDLE && !empty;
  assign raddr     = cur.corner_addr[step];
  assign we        = state == S_WRITE;
  assign last_step = cur.is_query ? step == 2'd3 : step == 2'd0;
  assign out_free  = !result.valid || result.ready;

  always_ff @(posedge clk) begin
    if (we) begin
      store[cur.write_addr] <= acc;
    end
    rdata <= store[raddr];
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (!empty) begin
          state_next = (head.is_query && head.status != STATUS_OK) ? S_OUT : S_READ;
        end
      end
      S_READ: begin
        if (last_step) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: state_next = cur.is_query ? S_OUT : S_WRITE;
      S_WRITE:  state_next = S_IDLE;
      S_OUT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      step         <= '0;
      pend_valid   <= 1'b0;
      result.valid <= 1'b0;
    end else begin
      state      <= state_next;
      pend_valid <= state == S_READ;
      if (state == S_IDLE) begin
        step <= '0;
      end else if (state == S_READ) begin
        step <= step + 2'd1;
      end
      if (state == S_OUT && out_free) begin
        result.valid <= 1'b1;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pend_used <= cur.corner_used[step];
    pend_neg  <= cur.is_query && (step == 2'd1 || step == 2'd2);
    if (pop) begin
      cur <= head;
      acc <= head.is_query ? '0 : head.load_sum;
    end else if (pend_valid && pend_used) begin
      acc <= pend_neg ? acc - rdata : acc + rdata;
    end
    if (state == S_OUT && out_free) begin
      result.region_sum <= acc;
      result.status     <= cur.status;
    end
  end

  a_error_sum_zero: assert property (@(posedge clk) disable iff (rst)
      result.valid && result.status != STATUS_OK |-> result.region_sum == '0)
    else $error("error result carries a nonzero sum");
  a_write_only_loads: assert property (@(posedge clk) disable iff (rst)
      we |-> !cur.is_query)
    else $error("table written while serving a query");
  a_out_from_query: assert property (@(posedge clk) disable iff (rst)
      state == S_OUT |-> cur.is_query)
    else $error("result produced for a load word");

endmodule

@@ sv/integral_image_region_sum.sv @@
// Top level of the summed-area table block: front end, command queue and
// back end. Depends on iirs_pkg, iirs_if, iirs_front, iirs_queue, iirs_back.
//
//   Channel  Dir  Word carries
//   item     in   kind, cell_value, top_row, left_column, bottom_row, right_column
//   result   out  region_sum, status
//   cfg      in   reg_index, reg_data (rows_in_use = 0, columns_in_use = 1)
//
// The back end serves one word at a time from a single-port table memory.
// A load word passes through read, finish and write; a valid query does its
// four corner reads, finish and output; an error query goes to output at once.
// Reset is synchronous and active high; the table itself is not cleared.
// The four-entry queue and the output register let the item side keep going
// while a result waits to be taken.
`timescale 1ns / 1ps

module integral_image_region_sum import iirs_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  iirs_item_if.sink      item,
  iirs_cfg_if.sink       cfg,
  iirs_result_if.source  result
);

  logic  push;
  cmd_t  push_cmd;
  logic  pop;
  cmd_t  head;
  logic  empty;
  logic  full;

  iirs_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .cfg        (cfg),
    .queue_full (full),
    .push       (push),
    .push_cmd   (push_cmd)
  );

  iirs_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .empty    (empty),
    .full     (full)
  );

  iirs_back u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .empty  (empty),
    .pop    (pop),
    .result (result)
  );

endmodule
